@@ src/egd_pkg.sv @@
// Package for the exp-Golomb stream decoder.
// Shared constants, FSM state type and controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package egd_pkg;

  localparam int VALUE_BITS_DEF = 32;  // default result width
  localparam int DATA_W         = 32;  // result tdata width
  localparam int CODE_W         = 5;   // code_order width
  localparam int SUM_W          = 7;   // order plus zero count plus one
  localparam int BYTE_BITS      = 8;
  localparam int CNT_W          = 3;   // bit index within a byte

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } egd_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take a byte request
    logic step;   // decode the current bit
    logic flush;  // move held result out, marked last
  } egd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bit_result;  // current bit finishes a code or an error
    logic pend_full;   // a result is held for the last flag
    logic out_free;    // output register can load this cycle
  } egd_status_t;

endpackage

@@ src/exp_golomb_stream_decoder.sv @@
// Order-k exp-Golomb stream decoder, MSB first, one bit per cycle unless results
// back up at the output; each byte request is eight bit steps plus a flush state
// that also takes the next byte.
// Reset: synchronous rst clears code_order, the partial code and the output.
`timescale 1ns / 1ps

module exp_golomb_stream_decoder #(
  parameter int VALUE_BITS = egd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [egd_pkg::CODE_W-1:0]    cfg_wdata,   // code_order
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [egd_pkg::BYTE_BITS-1:0] s_tdata,     // data_byte
  input  logic                          s_tuser,     // start_req
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [egd_pkg::DATA_W-1:0]    m_tdata,     // value
  output logic                          m_tuser,     // error
  output logic                          m_tlast      // last
);

  egd_pkg::egd_cmd_t    cmd;
  egd_pkg::egd_status_t st;

  egd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  egd_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .st        (st)
  );

`ifndef ASSERT_OFF
  // a step that makes a second result must find room for the held one
  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && st.bit_result && st.pend_full) |-> st.out_free)
    else $error("result step while held result cannot move out");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !st.pend_full)
    else $error("held result still present after flush");

  a_no_request_mid_byte: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!s_tready && !cmd.load && !cmd.flush))
    else $error("byte request taken while bits are being decoded");
`endif

endmodule

@@ src/egd_ctrl.sv @@
// Controller for the exp-Golomb stream decoder.
// Sequences load, eight bit steps and the end-of-byte flush. Uses egd_pkg.
`timescale 1ns / 1ps

module egd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  egd_pkg::egd_status_t st,
  output egd_pkg::egd_cmd_t    cmd
);

  egd_pkg::egd_state_t state, state_next;
  logic [egd_pkg::CNT_W-1:0] bit_cnt, bit_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= egd_pkg::ST_IDLE;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
    end
  end

  logic stall;
  logic can_done;

  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    cmd          = '0;
    s_tready     = 1'b0;
    // a second result in one byte needs the output register for the held one
    stall        = st.bit_result && st.pend_full && !st.out_free;
    can_done     = !st.pend_full || st.out_free;
    unique case (state)
      egd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load     = 1'b1;
          bit_cnt_next = '0;
          state_next   = egd_pkg::ST_RUN;
        end
      end
      egd_pkg::ST_RUN: begin
        if (!stall) begin
          cmd.step     = 1'b1;
          bit_cnt_next = bit_cnt + 1'b1;
          if (bit_cnt == egd_pkg::CNT_W'(egd_pkg::BYTE_BITS - 1)) begin
            state_next = egd_pkg::ST_FLUSH;
          end
        end
      end
      egd_pkg::ST_FLUSH: begin
        s_tready  = can_done;
        cmd.flush = st.pend_full && st.out_free;
        if (can_done) begin
          if (s_tvalid) begin
            cmd.load     = 1'b1;
            bit_cnt_next = '0;
            state_next   = egd_pkg::ST_RUN;
          end else begin
            state_next = egd_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = egd_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ src/egd_datapath.sv @@
// Datapath for the exp-Golomb stream decoder.
// Bit shifter, code state, value arithmetic, held result and output register.
// Uses egd_pkg; driven by egd_ctrl commands.
`timescale 1ns / 1ps

module egd_datapath #(
  parameter int VALUE_BITS = egd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [egd_pkg::CODE_W-1:0]    cfg_wdata,
  input  logic [egd_pkg::BYTE_BITS-1:0] s_tdata,
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [egd_pkg::DATA_W-1:0]    m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast,
  input  egd_pkg::egd_cmd_t             cmd,
  output egd_pkg::egd_status_t          st
);

  localparam int LW = $clog2(VALUE_BITS);
  localparam int AW = VALUE_BITS - 1;
  localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);

  logic [egd_pkg::CODE_W-1:0]    code_order;
  logic [egd_pkg::BYTE_BITS-1:0] shift;
  logic                          reading_suffix;
  logic [LW-1:0]                 suffix_length;
  logic [LW-1:0]                 suffix_bits_left;
  logic [AW-1:0]                 suffix_accumulator;

  logic                  pend_full;
  logic [VALUE_BITS-1:0] pend_value;
  logic                  pend_error;

  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_value;
  logic                  out_error;
  logic                  out_last;

  logic                      cur_bit;
  logic [egd_pkg::SUM_W-1:0] n_zero;
  logic [egd_pkg::SUM_W-1:0] n_one;
  logic                      ovf_zero, ovf_one;
  logic [AW-1:0]             acc_next;
  logic                      res_hit;
  logic                      res_error;
  logic [VALUE_BITS-1:0]     res_value;
  logic [VALUE_BITS-1:0]     pow_n, pow_k;
  logic                      out_free;

  always_comb begin
    cur_bit  = shift[egd_pkg::BYTE_BITS-1];
    n_zero   = egd_pkg::SUM_W'(code_order) + egd_pkg::SUM_W'(suffix_length) + 1'b1;
    n_one    = egd_pkg::SUM_W'(code_order) + egd_pkg::SUM_W'(suffix_length);
    ovf_zero = n_zero >= egd_pkg::SUM_W'(VALUE_BITS);
    ovf_one  = n_one >= egd_pkg::SUM_W'(VALUE_BITS);
    acc_next = {suffix_accumulator[AW-2:0], cur_bit};
    // 2^n + suffix - 2^k, wrapping; an order past the width drops out
    pow_n    = ONE << suffix_length;
    pow_k    = ONE << code_order;
    if (reading_suffix) begin
      res_hit   = suffix_bits_left == LW'(1);
      res_error = 1'b0;
      res_value = pow_n + VALUE_BITS'(acc_next) - pow_k;
    end else if (!cur_bit) begin
      res_hit   = ovf_zero;
      res_error = 1'b1;
      res_value = '0;
    end else begin
      // empty suffix finishes with value zero
      res_hit   = ovf_one || (n_one == '0);
      res_error = ovf_one;
      res_value = '0;
    end
    out_free      = !out_valid || m_tready;
    st.bit_result = res_hit;
    st.pend_full  = pend_full;
    st.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_order <= '0;
    end else if (cfg_we) begin
      code_order <= cfg_wdata;
    end
  end

  // code state
  always_ff @(posedge clk) begin
    if (rst) begin
      reading_suffix     <= 1'b0;
      suffix_length      <= '0;
      suffix_bits_left   <= '0;
      suffix_accumulator <= '0;
    end else if (cmd.load) begin
      if (s_tuser) begin
        reading_suffix     <= 1'b0;
        suffix_length      <= '0;
        suffix_bits_left   <= '0;
        suffix_accumulator <= '0;
      end
    end else if (cmd.step) begin
      if (res_hit) begin
        reading_suffix     <= 1'b0;
        suffix_length      <= '0;
        suffix_bits_left   <= '0;
        suffix_accumulator <= '0;
      end else if (reading_suffix) begin
        suffix_accumulator <= acc_next;
        suffix_bits_left   <= suffix_bits_left - 1'b1;
      end else if (!cur_bit) begin
        suffix_length <= suffix_length + 1'b1;
      end else begin
        reading_suffix     <= 1'b1;
        suffix_length      <= LW'(n_one);
        suffix_bits_left   <= LW'(n_one);
        suffix_accumulator <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift <= s_tdata;
    end else if (cmd.step) begin
      shift <= {shift[egd_pkg::BYTE_BITS-2:0], 1'b0};
    end
  end

  // held result: released with last=0 by the next result, last=1 by flush
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_full <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (cmd.step && res_hit) begin
        pend_full <= 1'b1;
        if (pend_full) begin
          out_valid <= 1'b1;
        end
      end else if (cmd.flush) begin
        pend_full <= 1'b0;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && res_hit) begin
      pend_value <= res_value;
      pend_error <= res_error;
      if (pend_full) begin
        out_value <= pend_value;
        out_error <= pend_error;
        out_last  <= 1'b0;
      end
    end else if (cmd.flush) begin
      out_value <= pend_value;
      out_error <= pend_error;
      out_last  <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = egd_pkg::DATA_W'(out_value);
  assign m_tuser  = out_error;
  assign m_tlast  = out_last;

endmodule
